FILE: rtl/core/best_fit_segment_cache_assert.svh
// assertion macros for the segment cache checker
`ifndef BEST_FIT_SEGMENT_CACHE_ASSERT_SVH
`define BEST_FIT_SEGMENT_CACHE_ASSERT_SVH

// same-cycle implication, checked while out of reset
`define BFSC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bfsc checker: property failed");

// next-cycle implication, checked while out of reset
`define BFSC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bfsc checker: property failed");

`endif

FILE: rtl/core/bfsc_pkg.sv
package bfsc_pkg;

    localparam int CACHE_ENTRIES = 4;
    localparam int IDX_W         = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int DATA_W        = 32;

    localparam logic MODE_GET = 1'b0;
    localparam logic MODE_ADD = 1'b1;

    // scan token handed from cell to cell
    typedef struct packed {
        logic              mode;
        logic [DATA_W-1:0] size;
        logic [DATA_W-1:0] handle;
        logic              found;
        logic              locked;
        logic [IDX_W-1:0]  cand_idx;
        logic [DATA_W-1:0] cand_size;
        logic [DATA_W-1:0] cand_handle;
        logic              empty_found;
        logic [IDX_W-1:0]  empty_idx;
    } t_tok;

    // slot update broadcast to the cells
    typedef struct packed {
        logic              set;
        logic              clr;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] size;
        logic [DATA_W-1:0] handle;
    } t_wr;

    typedef struct packed {
        logic              ok;
        logic [DATA_W-1:0] out_handle;
        logic [DATA_W-1:0] out_size;
        logic              evicted;
        logic [DATA_W-1:0] evicted_handle;
    } t_res;

endpackage

FILE: rtl/core/bfsc_if.sv
interface bfsc_in_if;
    logic                       valid;
    logic                       ready;
    logic                       mode;
    logic [bfsc_pkg::DATA_W-1:0] req_size;
    logic [bfsc_pkg::DATA_W-1:0] seg_handle;

    modport source (output valid, output mode, output req_size, output seg_handle,
                    input ready);
    modport sink   (input valid, input mode, input req_size, input seg_handle,
                    output ready);
endinterface

interface bfsc_out_if;
    logic                       valid;
    logic                       ready;
    logic                       ok;
    logic [bfsc_pkg::DATA_W-1:0] out_handle;
    logic [bfsc_pkg::DATA_W-1:0] out_size;
    logic                       evicted;
    logic [bfsc_pkg::DATA_W-1:0] evicted_handle;

    modport source (output valid, output ok, output out_handle, output out_size,
                    output evicted, output evicted_handle, input ready);
    modport sink   (input valid, input ok, input out_handle, input out_size,
                    input evicted, input evicted_handle, output ready);
endinterface

FILE: rtl/core/bfsc_cell.sv
module bfsc_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [bfsc_pkg::IDX_W-1:0]   i_idx,
    input  logic                         i_tok_vld,
    input  bfsc_pkg::t_tok               i_tok,
    input  bfsc_pkg::t_wr                i_wr,
    output logic                         o_tok_vld,
    output bfsc_pkg::t_tok               o_tok
);

    logic                          r_vld;
    logic [bfsc_pkg::DATA_W-1:0]   r_size;
    logic [bfsc_pkg::DATA_W-1:0]   r_handle;
    logic                          r_tok_vld;
    bfsc_pkg::t_tok                r_tok;
    bfsc_pkg::t_tok                n_tok;
    logic                          w_eq;
    logic                          w_gt;
    logic                          w_lt;
    logic                          w_better;
    logic                          w_sel;

    assign w_eq     = (r_size == i_tok.size);
    assign w_gt     = (r_size >  i_tok.size);
    assign w_lt     = (r_size <  i_tok.size);
    assign w_better = !i_tok.found || (r_size < i_tok.cand_size);
    assign w_sel    = (i_wr.idx == i_idx);

    always_comb begin
        n_tok = i_tok;
        case (i_tok.mode)
            bfsc_pkg::MODE_GET: begin
                // first exact match locks the choice
                if (r_vld && !i_tok.locked) begin
                    if (w_eq) begin
                        n_tok.found       = 1'b1;
                        n_tok.locked      = 1'b1;
                        n_tok.cand_idx    = i_idx;
                        n_tok.cand_size   = r_size;
                        n_tok.cand_handle = r_handle;
                    end else if (w_gt && w_better) begin
                        n_tok.found       = 1'b1;
                        n_tok.cand_idx    = i_idx;
                        n_tok.cand_size   = r_size;
                        n_tok.cand_handle = r_handle;
                    end
                end
            end
            bfsc_pkg::MODE_ADD: begin
                if (!r_vld) begin
                    if (!i_tok.empty_found) begin
                        n_tok.empty_found = 1'b1;
                        n_tok.empty_idx   = i_idx;
                    end
                end else if (w_lt && w_better) begin
                    n_tok.found       = 1'b1;
                    n_tok.cand_idx    = i_idx;
                    n_tok.cand_size   = r_size;
                    n_tok.cand_handle = r_handle;
                end
            end
            default: n_tok = i_tok;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= 1'b0;
            r_tok_vld <= 1'b0;
        end else begin
            r_tok_vld <= i_tok_vld;
            if (w_sel && i_wr.set) begin
                r_vld <= 1'b1;
            end else if (w_sel && i_wr.clr) begin
                r_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok <= n_tok;
        if (w_sel && i_wr.set) begin
            r_size   <= i_wr.size;
            r_handle <= i_wr.handle;
        end
    end

    assign o_tok_vld = r_tok_vld;
    assign o_tok     = r_tok;

endmodule

FILE: rtl/core/best_fit_segment_cache.sv
// a request's scan token walks the cell chain one cell per cycle, then waits in
// r_pend for the commit into r_out, whose result shows on o_out; a new request is
// taken only after the last one commits, and the commit waits while o_out holds an
// untaken result; a result waiting on o_out does not block the next input transfer
// reset: synchronous active low, all slots empty, no request in flight
module best_fit_segment_cache (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bfsc_in_if.sink     i_in,
    bfsc_out_if.source  o_out
);

    localparam int N = bfsc_pkg::CACHE_ENTRIES;

    logic              w_tok_vld [N+1];
    bfsc_pkg::t_tok    w_tok     [N+1];
    logic              w_accept;
    logic              w_commit;
    logic              r_busy;
    logic              r_pend_vld;
    bfsc_pkg::t_tok    r_pend;
    logic              r_out_vld;
    bfsc_pkg::t_res    r_out;
    bfsc_pkg::t_res    n_res;
    bfsc_pkg::t_wr     n_wr;

    assign i_in.ready = !r_busy;
    assign w_accept   = i_in.valid && !r_busy;
    assign w_commit   = r_pend_vld && (!r_out_vld || o_out.ready);

    always_comb begin
        w_tok_vld[0]         = w_accept;
        w_tok[0]             = '0;
        w_tok[0].mode        = i_in.mode;
        w_tok[0].size        = i_in.req_size;
        w_tok[0].handle      = i_in.seg_handle;
    end

    for (genvar k = 0; k < N; k++) begin : g_cell
        bfsc_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_idx     (bfsc_pkg::IDX_W'(k)),
            .i_tok_vld (w_tok_vld[k]),
            .i_tok     (w_tok[k]),
            .i_wr      (n_wr),
            .o_tok_vld (w_tok_vld[k+1]),
            .o_tok     (w_tok[k+1])
        );
    end

    // decide the result and the slot update from the finished scan
    always_comb begin
        n_res        = '0;
        n_wr         = '0;
        n_wr.size    = r_pend.size;
        n_wr.handle  = r_pend.handle;
        case (r_pend.mode)
            bfsc_pkg::MODE_GET: begin
                if (r_pend.found) begin
                    n_res.ok         = 1'b1;
                    n_res.out_handle = r_pend.cand_handle;
                    n_res.out_size   = r_pend.cand_size;
                    n_wr.clr         = w_commit;
                    n_wr.idx         = r_pend.cand_idx;
                end
            end
            bfsc_pkg::MODE_ADD: begin
                if (r_pend.empty_found) begin
                    n_res.ok = 1'b1;
                    n_wr.set = w_commit;
                    n_wr.idx = r_pend.empty_idx;
                end else if (r_pend.found) begin
                    n_res.ok             = 1'b1;
                    n_res.evicted        = 1'b1;
                    n_res.evicted_handle = r_pend.cand_handle;
                    n_wr.set             = w_commit;
                    n_wr.idx             = r_pend.cand_idx;
                end
            end
            default: n_res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_commit) begin
                r_busy <= 1'b0;
            end
            if (w_tok_vld[N]) begin
                r_pend_vld <= 1'b1;
            end else if (w_commit) begin
                r_pend_vld <= 1'b0;
            end
            if (w_commit) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_tok_vld[N]) begin
            r_pend <= w_tok[N];
        end
        if (w_commit) begin
            r_out <= n_res;
        end
    end

    assign o_out.valid          = r_out_vld;
    assign o_out.ok             = r_out.ok;
    assign o_out.out_handle     = r_out.out_handle;
    assign o_out.out_size       = r_out.out_size;
    assign o_out.evicted        = r_out.evicted;
    assign o_out.evicted_handle = r_out.evicted_handle;

endmodule

FILE: rtl/core/bfsc_checker.sv
`include "best_fit_segment_cache_assert.svh"

module bfsc_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic                        i_ok,
    input  logic [bfsc_pkg::DATA_W-1:0] i_out_handle,
    input  logic [bfsc_pkg::DATA_W-1:0] i_out_size,
    input  logic                        i_evicted,
    input  logic [bfsc_pkg::DATA_W-1:0] i_evicted_handle
);

    // only one request in flight
    `BFSC_ASSERT_NEXT(a_busy_after_accept, i_in_valid && i_in_ready, !i_in_ready)

    // a stalled result holds
    `BFSC_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_ok) && $stable(i_out_handle) && $stable(i_out_size)
        && $stable(i_evicted) && $stable(i_evicted_handle))

    // a miss or a rejected add carries only zeros
    `BFSC_ASSERT_NOW(a_miss_zero, i_out_valid && !i_ok,
        i_out_handle == '0 && i_out_size == '0 && !i_evicted && i_evicted_handle == '0)

    // an eviction only comes from a stored add
    `BFSC_ASSERT_NOW(a_evict_is_add, i_out_valid && i_evicted,
        i_ok && i_out_handle == '0 && i_out_size == '0)

endmodule

bind best_fit_segment_cache bfsc_checker u_bfsc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_ok             (o_out.ok),
    .i_out_handle     (o_out.out_handle),
    .i_out_size       (o_out.out_size),
    .i_evicted        (o_out.evicted),
    .i_evicted_handle (o_out.evicted_handle)
);
